// ----- rtl/ste_pkg.sv -----
// Shared types and constants for the sorted table engine.
package ste_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic               insert_en;
    logic               delete_en;
    logic [VALUE_W-1:0] value;
  } cmd_t;

endpackage

// ----- rtl/ste_cell.sv -----
// One entry of the sorted row with its local compare and shift logic.
module ste_cell (
  input  logic                         clk_i,
  input  ste_pkg::cmd_t                cmd_i,
  input  logic                         valid_i,
  input  logic [ste_pkg::VALUE_W-1:0]  left_entry_i,
  input  logic                         left_lt_i,
  input  logic                         left_below_i,
  input  logic [ste_pkg::VALUE_W-1:0]  right_entry_i,
  output logic [ste_pkg::VALUE_W-1:0]  entry_o,
  output logic                         lt_o,
  output logic                         below_o,
  output logic                         hit_o
);

  logic [ste_pkg::VALUE_W-1:0] entry_q, entry_d;

  // The new value sorts before this entry (an empty slot counts as larger).
  assign lt_o    = !valid_i || ($signed(cmd_i.value) < $signed(entry_q));
  // This entry is smaller than the value.
  assign below_o = valid_i && ($signed(entry_q) < $signed(cmd_i.value));
  // First equal entry: everything to the left is smaller.
  assign hit_o   = valid_i && (entry_q == cmd_i.value) && left_below_i;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    priority if (cmd_i.insert_en && lt_o) begin
      entry_d = left_lt_i ? left_entry_i : cmd_i.value;
    end else if (cmd_i.delete_en && valid_i && !below_o) begin
      entry_d = right_entry_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ----- rtl/ste_reduce.sv -----
// Reductions across the row: match index encoding and last-entry select.
module ste_reduce (
  input  logic [ste_pkg::DEPTH-1:0]   hit_i,
  input  logic [ste_pkg::VALUE_W-1:0] entries_i [ste_pkg::DEPTH],
  input  logic [ste_pkg::COUNT_W-1:0] count_i,
  output logic                        found_o,
  output logic [ste_pkg::COUNT_W-1:0] match_index_o,
  output logic [ste_pkg::VALUE_W-1:0] largest_o
);

  assign found_o = |hit_i;

  // At most one hit and one last entry exist, so an AND-OR tree selects them.
  always_comb begin
    match_index_o = '0;
    largest_o     = '0;
    for (int i = 0; i < ste_pkg::DEPTH; i++) begin
      if (hit_i[i]) begin
        match_index_o = match_index_o | ste_pkg::COUNT_W'(i + 1);
      end
      if (count_i == ste_pkg::COUNT_W'(i + 1)) begin
        largest_o = largest_o | entries_i[i];
      end
    end
  end

endmodule

// ----- rtl/sorted_table_engine.sv -----
// Top level of the sorted table engine: cell row, count and result stages.
//
// The block keeps up to DEPTH signed values in ascending order. Each input
// beat carries an operation (insert, delete first equal entry, search) and a
// value; each input beat yields exactly one output beat with a status, the
// 1-based match index, the entry count, the smallest and largest entries and
// an empty flag, all describing the table after the operation.
// Both channels use valid and stall: a beat moves at a rising edge where
// valid is high and stall is low.
// A beat passes the middle stage, then the output register. One beat is
// taken every cycle while in_stall_o is low: every cell compares the value
// against its own entry and shifts left or right by one place in the same
// cycle, so the row never iterates. The output register reads the updated row.
// When the receiver stalls, the output register holds its beat, the middle
// stage fills, and then in_stall_o rises until the output beat is taken.
// Reset empties the table (count zero) and drops any beat in flight; the
// entry storage itself is not cleared, since only entries below the count
// are ever read. No clearing pass is needed and the block is ready at once.
module sorted_table_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   operation_i,
  input  logic signed [31:0]           value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [4:0]                   match_index_o,
  output logic [4:0]                   entry_count_o,
  output logic signed [31:0]           smallest_o,
  output logic signed [31:0]           largest_o,
  output logic                         is_empty_o
);

  localparam int unsigned Depth  = ste_pkg::DEPTH;
  localparam int unsigned CountW = ste_pkg::COUNT_W;
  localparam int unsigned ValueW = ste_pkg::VALUE_W;

  // Cell row wiring.
  ste_pkg::cmd_t     cmd;
  logic [ValueW-1:0] entries [Depth];
  logic [Depth-1:0]  cell_valid;
  logic [Depth-1:0]  lt;
  logic [Depth-1:0]  below;
  logic [Depth-1:0]  hit;

  // Table count and pipeline registers.
  logic [CountW-1:0] count_q, count_d;
  logic              mid_valid_q, mid_valid_d;
  ste_pkg::status_e  mid_status_q, mid_status_d;
  logic [CountW-1:0] mid_match_q, mid_match_d;
  logic              out_valid_q, out_valid_d;
  ste_pkg::status_e  out_status_q;
  logic [CountW-1:0] out_match_q;
  logic [CountW-1:0] out_count_q;
  logic [ValueW-1:0] out_small_q;
  logic [ValueW-1:0] out_large_q;
  logic              out_empty_q;

  logic              accept;
  logic              out_take;
  logic              full;
  logic              found;
  logic [CountW-1:0] match_idx;
  logic [ValueW-1:0] last_entry;

  // The output register takes a new beat when it is empty or being drained.
  assign out_take   = !out_valid_q || !out_stall_i;
  assign in_stall_o = mid_valid_q && !out_take;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CountW'(Depth));

  assign cmd.value     = value_i;
  assign cmd.insert_en = accept && (operation_i == ste_pkg::OP_INSERT) && !full;
  assign cmd.delete_en = accept && (operation_i == ste_pkg::OP_DELETE) && found;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [ValueW-1:0] left_entry;
    logic              left_lt;
    logic              left_below;
    logic [ValueW-1:0] right_entry;

    assign cell_valid[i] = (count_q > CountW'(i));

    if (i == 0) begin : g_first
      assign left_entry  = cmd.value;
      assign left_lt     = 1'b0;
      assign left_below  = 1'b1;
    end else begin : g_inner
      assign left_entry  = entries[i-1];
      assign left_lt     = lt[i-1];
      assign left_below  = below[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_body
      assign right_entry = entries[i+1];
    end

    ste_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .valid_i       (cell_valid[i]),
      .left_entry_i  (left_entry),
      .left_lt_i     (left_lt),
      .left_below_i  (left_below),
      .right_entry_i (right_entry),
      .entry_o       (entries[i]),
      .lt_o          (lt[i]),
      .below_o       (below[i]),
      .hit_o         (hit[i])
    );
  end

  // Match lookup uses the row before the update; the largest entry is read
  // from the row after it, against the updated count.
  ste_reduce u_reduce (
    .hit_i         (hit),
    .entries_i     (entries),
    .count_i       (count_q),
    .found_o       (found),
    .match_index_o (match_idx),
    .largest_o     (last_entry)
  );

  // Result of the accepted operation and the new count.
  always_comb begin
    count_d      = count_q;
    mid_status_d = mid_status_q;
    mid_match_d  = mid_match_q;
    if (accept) begin
      mid_status_d = ste_pkg::ST_DONE;
      mid_match_d  = '0;
      unique case (operation_i)
        ste_pkg::OP_INSERT: begin
          if (full) begin
            mid_status_d = ste_pkg::ST_FULL;
          end else begin
            count_d = count_q + CountW'(1);
          end
        end
        ste_pkg::OP_DELETE, ste_pkg::OP_SEARCH: begin
          if (found) begin
            mid_match_d = match_idx;
            if (operation_i == ste_pkg::OP_DELETE) begin
              count_d = count_q - CountW'(1);
            end
          end else begin
            mid_status_d = ste_pkg::ST_NOT_FOUND;
          end
        end
        default: begin
          // The unused code leaves the table alone and reports it as it is.
        end
      endcase
    end
  end

  always_comb begin
    mid_valid_d = mid_valid_q;
    out_valid_d = out_valid_q;
    if (out_take) begin
      out_valid_d = mid_valid_q;
      mid_valid_d = 1'b0;
    end
    if (accept) begin
      mid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      mid_valid_q <= mid_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mid_status_q <= mid_status_d;
    mid_match_q  <= mid_match_d;
    if (out_take && mid_valid_q) begin
      out_status_q <= mid_status_q;
      out_match_q  <= mid_match_q;
      out_count_q  <= count_q;
      out_small_q  <= (count_q != '0) ? entries[0] : '0;
      out_large_q  <= last_entry;
      out_empty_q  <= (count_q == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign match_index_o = out_match_q;
  assign entry_count_o = out_count_q;
  assign smallest_o    = out_small_q;
  assign largest_o     = out_large_q;
  assign is_empty_o    = out_empty_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(Depth))
    else $error("entry count exceeds the table depth");

  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit))
    else $error("more than one cell claims the first match");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.insert_en |=> count_q == $past(count_q) + CountW'(1))
    else $error("insert did not grow the table by one");

  a_delete_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.delete_en |=> count_q == $past(count_q) - CountW'(1))
    else $error("delete did not shrink the table by one");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (mid_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked output");
`endif

endmodule
